// File: src/qtl_pkg.sv
// shared types, constants and helpers for the two-level request queue
`timescale 1ns / 1ps
`default_nettype none

package qtl_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int ID_W    = 16;
  localparam int WCFG_W  = 20;
  localparam int WAIT_W  = 21;
  localparam int BATCH_W = 8;
  localparam int CFG_W   = 20;
  localparam int IDX_W   = 3;

  localparam logic [WAIT_W-1:0]  WAIT_CAP        = 21'd1310719;
  localparam logic [BATCH_W-1:0] BATCH_SAT       = 8'd255;
  localparam logic [WCFG_W-1:0]  RST_DEFAULT_WAIT = 20'd20000;
  localparam logic [WCFG_W-1:0]  RST_MIN_WAIT     = 20'd10000;
  localparam logic [WCFG_W-1:0]  RST_MAX_WAIT     = 20'd1000000;
  localparam logic [BATCH_W-1:0] RST_MIN_BATCH    = 8'd32;
  localparam logic [BATCH_W-1:0] RST_MAX_BATCH    = 8'd64;

  // request codes
  localparam logic [1:0] REQ_ENQUEUE  = 2'd0;
  localparam logic [1:0] REQ_POLL     = 2'd1;
  localparam logic [1:0] REQ_WAIT_END = 2'd2;
  localparam logic [1:0] REQ_SHUTDOWN = 2'd3;

  // result status codes
  localparam logic [2:0] STS_ACCEPTED  = 3'd0;
  localparam logic [2:0] STS_REJECTED  = 3'd1;
  localparam logic [2:0] STS_DELIVERED = 3'd2;
  localparam logic [2:0] STS_WAIT      = 3'd3;
  localparam logic [2:0] STS_FINISHED  = 3'd4;
  localparam logic [2:0] STS_SHUTDOWN  = 3'd5;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_DEFAULT_WAIT = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN_WAIT     = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAX_WAIT     = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIN_BATCH    = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_BATCH    = 3'd4;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [ID_W-1:0]  wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ID_W-1:0]   out_id;
    logic              wake_worker;
    logic [WAIT_W-1:0] wait_time;
    logic              is_dormant;
  } result_t;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    bump = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

`default_nettype wire

// File: src/qtl_ram.sv
// handle store: one write and one registered read per cycle
`timescale 1ns / 1ps
`default_nettype none

module qtl_ram
  import qtl_pkg::*;
(
  input  wire logic            clk,
  input  wire ram_req_t        req,
  output logic [ID_W-1:0]      rdata
);

  logic [ID_W-1:0] mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/qtl_ctrl.sv
// sequencer: queue pointers, config registers and timeout tuning
`timescale 1ns / 1ps
`default_nettype none

module qtl_ctrl
  import qtl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         req_type,
  input  wire logic [ID_W-1:0]    req_id,
  input  wire logic               is_retry,
  input  wire logic               is_unbatched,
  input  wire logic               out_free,
  output logic                    res_load,
  output result_t                 res,
  output ram_req_t                retry_req,
  output ram_req_t                main_req,
  input  wire logic [ID_W-1:0]    retry_rdata,
  input  wire logic [ID_W-1:0]    main_rdata
);

  state_t state, state_next;
  logic   accept;

  logic [WCFG_W-1:0]  default_wait, min_wait, max_wait;
  logic [BATCH_W-1:0] min_batch, max_batch;

  logic [PTR_W-1:0]   retry_head, retry_tail, main_head, main_tail;
  logic [CNT_W-1:0]   retry_count, main_count;
  logic [WAIT_W-1:0]  wait_now;
  logic [BATCH_W-1:0] batch_count;
  logic               dormant_flag, alive_flag;

  // item held while it executes
  logic [1:0]         cur_type;
  logic [ID_W-1:0]    cur_id;
  logic               cur_retry, cur_unbatched;

  // next values
  logic [PTR_W-1:0]   retry_head_next, retry_tail_next, main_head_next, main_tail_next;
  logic [CNT_W-1:0]   retry_count_next, main_count_next;
  logic [WAIT_W-1:0]  wait_next;
  logic [BATCH_W-1:0] batch_next;
  logic               dormant_next, alive_next;
  logic               retry_we, main_we;

  logic               retry_full, main_full, have_retry, have_main, got;
  logic [BATCH_W-1:0] batch_inc;
  logic [WAIT_W:0]    grow_sum;
  logic [WAIT_W-1:0]  grown, shrink_diff, shrunk;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_wait <= RST_DEFAULT_WAIT;
      min_wait     <= RST_MIN_WAIT;
      max_wait     <= RST_MAX_WAIT;
      min_batch    <= RST_MIN_BATCH;
      max_batch    <= RST_MAX_BATCH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEFAULT_WAIT: default_wait <= cfg_data;
        REG_MIN_WAIT:     min_wait     <= cfg_data;
        REG_MAX_WAIT:     max_wait     <= cfg_data;
        REG_MIN_BATCH:    min_batch    <= cfg_data[BATCH_W-1:0];
        REG_MAX_BATCH:    max_batch    <= cfg_data[BATCH_W-1:0];
        default: ;
      endcase
    end
  end

  // fsm
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_EXEC;
      ST_EXEC: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    res_load = (state == ST_EXEC) && out_free;
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_type      <= req_type;
      cur_id        <= req_id;
      cur_retry     <= is_retry;
      cur_unbatched <= is_unbatched;
    end
  end

  // both heads are read on accept so the data is ready for a pop
  always_comb begin
    retry_req.re    = accept;
    retry_req.raddr = retry_head;
    retry_req.we    = retry_we;
    retry_req.waddr = retry_tail;
    retry_req.wdata = cur_id;
    main_req.re     = accept;
    main_req.raddr  = main_head;
    main_req.we     = main_we;
    main_req.waddr  = main_tail;
    main_req.wdata  = cur_id;
  end

  // timeout tuning datapath
  always_comb begin
    grow_sum    = {1'b0, wait_now} + {3'b000, wait_now[WAIT_W-1:2]};
    grown       = (grow_sum > {1'b0, WAIT_CAP}) ? WAIT_CAP : grow_sum[WAIT_W-1:0];
    shrink_diff = wait_now - {2'b00, wait_now[WAIT_W-1:2]};
    shrunk      = (shrink_diff < {1'b0, min_wait}) ? {1'b0, min_wait} : shrink_diff;
  end

  always_comb begin
    retry_full = (retry_count == CNT_W'(QUEUE_DEPTH));
    main_full  = (main_count == CNT_W'(QUEUE_DEPTH));
    have_retry = (retry_count != '0);
    have_main  = (main_count != '0);
    got        = have_retry || have_main;
    batch_inc  = (batch_count == BATCH_SAT) ? batch_count : batch_count + BATCH_W'(1);

    retry_head_next  = retry_head;
    retry_tail_next  = retry_tail;
    retry_count_next = retry_count;
    main_head_next   = main_head;
    main_tail_next   = main_tail;
    main_count_next  = main_count;
    wait_next        = wait_now;
    batch_next       = batch_count;
    dormant_next     = dormant_flag;
    alive_next       = alive_flag;
    retry_we         = 1'b0;
    main_we          = 1'b0;

    res.status      = STS_REJECTED;
    res.out_id      = '0;
    res.wake_worker = 1'b0;

    unique case (cur_type)
      REQ_ENQUEUE: begin
        if (alive_flag && cur_retry && !retry_full) begin
          retry_we         = res_load;
          retry_tail_next  = bump(retry_tail);
          retry_count_next = retry_count + CNT_W'(1);
          res.status       = STS_ACCEPTED;
        end else if (alive_flag && !cur_retry && !main_full) begin
          main_we          = res_load;
          main_tail_next   = bump(main_tail);
          main_count_next  = main_count + CNT_W'(1);
          res.status       = STS_ACCEPTED;
        end
        res.wake_worker = (res.status == STS_ACCEPTED) && (dormant_flag || cur_unbatched);
      end
      REQ_SHUTDOWN: begin
        alive_next = 1'b0;
        res.status = STS_SHUTDOWN;
      end
      REQ_POLL, REQ_WAIT_END: begin
        if (have_retry) begin
          res.out_id       = retry_rdata;
          retry_head_next  = bump(retry_head);
          retry_count_next = retry_count - CNT_W'(1);
        end else if (have_main) begin
          res.out_id      = main_rdata;
          main_head_next  = bump(main_head);
          main_count_next = main_count - CNT_W'(1);
        end
        if (got) begin
          res.status = STS_DELIVERED;
          batch_next = batch_inc;
        end else if (!alive_flag) begin
          res.status = STS_FINISHED;
        end else begin
          res.status = STS_WAIT;
        end
        if (res.status != STS_FINISHED) begin
          if (dormant_flag) begin
            if (got || cur_type == REQ_WAIT_END) begin
              dormant_next = 1'b0;
              wait_next    = {1'b0, default_wait};
            end
          end else if (cur_type == REQ_WAIT_END) begin
            // tuning sees the count after this pop
            if (batch_next < min_batch) begin
              wait_next    = grown;
              dormant_next = (grown >= {1'b0, max_wait});
            end else if (batch_next > max_batch) begin
              wait_next = shrunk;
            end
            batch_next = '0;
          end
        end
      end
      default: ;
    endcase

    res.wait_time  = wait_next;
    res.is_dormant = dormant_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_head   <= '0;
      retry_tail   <= '0;
      retry_count  <= '0;
      main_head    <= '0;
      main_tail    <= '0;
      main_count   <= '0;
      wait_now     <= {1'b0, RST_DEFAULT_WAIT};
      batch_count  <= '0;
      dormant_flag <= 1'b0;
      alive_flag   <= 1'b1;
    end else if (res_load) begin
      retry_head   <= retry_head_next;
      retry_tail   <= retry_tail_next;
      retry_count  <= retry_count_next;
      main_head    <= main_head_next;
      main_tail    <= main_tail_next;
      main_count   <= main_count_next;
      wait_now     <= wait_next;
      batch_count  <= batch_next;
      dormant_flag <= dormant_next;
      alive_flag   <= alive_next;
    end
  end

endmodule

`default_nettype wire

// File: src/two_level_queue_adaptive_wait.sv
// top level: two handle stores, sequencer and output register
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  cfg     | in        | cfg_we              | cfg_index, cfg_data
//  in      | in        | in_valid / in_stall | req_type, req_id, is_retry, is_unbatched
//  out     | out       | out_valid/out_stall | status, out_id, wake_worker, wait_time,
//          |           |                     | is_dormant
//
// each item first does the registered read of both store heads, then updates
// pointers and timeout and loads the output register.
// the result register frees the sequencer, so a new item is taken while a result waits;
// a result that cannot leave holds the sequencer in its update cycle.
// synchronous reset clears pointers, counts and flags; store contents stay undefined.
`timescale 1ns / 1ps
`default_nettype none

module two_level_queue_adaptive_wait
  import qtl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        req_type,
  input  wire logic [ID_W-1:0]   req_id,
  input  wire logic              is_retry,
  input  wire logic              is_unbatched,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             status,
  output logic [ID_W-1:0]        out_id,
  output logic                   wake_worker,
  output logic [WAIT_W-1:0]      wait_time,
  output logic                   is_dormant
);

  ram_req_t        retry_req, main_req;
  logic [ID_W-1:0] retry_rdata, main_rdata;
  logic            out_free, res_load;
  result_t         res;

  assign out_free = !out_valid || !out_stall;

  qtl_ram u_retry_ram (
    .clk   (clk),
    .req   (retry_req),
    .rdata (retry_rdata)
  );

  qtl_ram u_main_ram (
    .clk   (clk),
    .req   (main_req),
    .rdata (main_rdata)
  );

  qtl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .req_id       (req_id),
    .is_retry     (is_retry),
    .is_unbatched (is_unbatched),
    .out_free     (out_free),
    .res_load     (res_load),
    .res          (res),
    .retry_req    (retry_req),
    .main_req     (main_req),
    .retry_rdata  (retry_rdata),
    .main_rdata   (main_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status      <= res.status;
      out_id      <= res.out_id;
      wake_worker <= res.wake_worker;
      wait_time   <= res.wait_time;
      is_dormant  <= res.is_dormant;
    end
  end

endmodule

`default_nettype wire

// File: src/qtl_checker.sv
// port-level checks for the two-level request queue, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module qtl_checker
  import qtl_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [2:0]        status,
  input wire logic [ID_W-1:0]   out_id,
  input wire logic              wake_worker,
  input wire logic [WAIT_W-1:0] wait_time,
  input wire logic              is_dormant
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_id)
      && $stable(wait_time) && $stable(is_dormant))
    else $error("stalled result changed");

  // one item at a time: busy right after a transfer in
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item executes");

  a_id_only_delivered: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STS_DELIVERED |-> out_id == '0)
    else $error("handle shown without delivery");

  a_wake_only_accepted: assert property (@(posedge clk) disable iff (rst)
    out_valid && wake_worker |-> status == STS_ACCEPTED)
    else $error("wake without accepted enqueue");

endmodule

bind two_level_queue_adaptive_wait qtl_checker u_qtl_checker (.*);

`default_nettype wire
